>>> rtl/khct_pkg.sv
`timescale 1ns / 1ps
package khct_pkg;
	localparam int TableDepth = 4096;
	localparam int SlotW = $clog2(TableDepth);
	localparam int SizeW = 13;
	localparam int KmerLen = 21;
	localparam int KmerW = 62;
	localparam int KeyW = 2 * KmerLen;
	localparam int CountW = 32;
	localparam int HashW = 64;
	localparam int ShiftA = 6;
	localparam int ShiftB = 16;
	localparam int BaseCntW = $clog2(KmerLen + 1);
	localparam int RemStepW = $clog2(HashW + 1);
	localparam int MemW = 1 + KeyW + CountW;
	localparam int QDepth = 2;
	localparam int QPtrW = $clog2(QDepth);
	localparam int QCntW = $clog2(QDepth + 1);

	typedef struct packed {
		logic mode;
		logic [KmerW-1:0] kmer_bases;
	} in_word_t;

	typedef struct packed {
		logic found;
		logic [SlotW-1:0] slot;
		logic [CountW-1:0] occurrences;
		logic table_full;
	} out_word_t;

	typedef struct packed {
		logic mode;
		logic [KeyW-1:0] key;
		logic [SlotW-1:0] start;
	} job_t;

	function automatic logic [7:0] base_letter(input logic [1:0] b);
		logic [7:0] r;
		case (b)
			2'd0: r = 8'h41;
			2'd1: r = 8'h43;
			2'd2: r = 8'h47;
			default: r = 8'h54;
		endcase
		return r;
	endfunction
endpackage

>>> rtl/khct_if.sv
`timescale 1ns / 1ps
interface khct_in_if;
	import khct_pkg::*;
	logic valid;
	logic ready;
	in_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface khct_out_if;
	import khct_pkg::*;
	logic valid;
	logic ready;
	out_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface khct_cfg_if;
	import khct_pkg::*;
	logic valid;
	logic ready;
	logic [SizeW-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> rtl/khct_ram.sv
`timescale 1ns / 1ps
module khct_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/khct_front.sv
`timescale 1ns / 1ps
// hash one base per cycle, then restoring remainder one bit per cycle
module khct_front (
	input  logic clk,
	input  logic arst_n,
	input  logic [khct_pkg::SizeW-1:0] eff_size,
	khct_in_if.sink in_ch,
	output logic job_valid,
	input  logic job_ready,
	output khct_pkg::job_t job
);
	import khct_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_HASH = 3'b010,
		F_REM  = 3'b100
	} fstate_t;

	fstate_t state_q;
	logic [BaseCntW-1:0] cnt_q;
	logic [RemStepW-1:0] bit_q;
	logic [HashW-1:0] hash_q;
	logic [SizeW:0] rem_q;
	logic [KeyW-1:0] key_q;
	logic mode_q;
	logic done_q;
	logic [1:0] base;
	logic [SizeW:0] rem_sh;

	assign in_ch.ready = (state_q == F_IDLE) && !done_q;
	assign base = key_q[KeyW-1 -: 2];
	assign rem_sh = {rem_q[SizeW-1:0], hash_q[HashW-1]};
	assign job_valid = done_q;
	assign job.mode = mode_q;
	assign job.key = key_q;
	assign job.start = rem_q[SlotW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q <= 1'b0;
			cnt_q <= '0;
			bit_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (done_q && job_ready) done_q <= 1'b0;
					if (in_ch.valid && in_ch.ready) begin
						mode_q <= in_ch.data.mode;
						key_q <= in_ch.data.kmer_bases[KeyW-1:0];
						hash_q <= '0;
						cnt_q <= '0;
						state_q <= F_HASH;
					end
				end
				F_HASH: begin
					hash_q <= HashW'(base_letter(base)) + (hash_q << ShiftA)
						+ (hash_q << ShiftB) - hash_q;
					key_q <= {key_q[KeyW-3:0], base};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == BaseCntW'(KmerLen - 1)) begin
						rem_q <= '0;
						bit_q <= '0;
						state_q <= F_REM;
					end
				end
				F_REM: begin
					if (rem_sh >= {1'b0, eff_size}) rem_q <= rem_sh - {1'b0, eff_size};
					else rem_q <= rem_sh;
					hash_q <= {hash_q[HashW-2:0], 1'b0};
					bit_q <= bit_q + 1'b1;
					if (bit_q == RemStepW'(HashW - 1)) begin
						done_q <= 1'b1;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/khct_queue.sv
`timescale 1ns / 1ps
module khct_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  khct_pkg::job_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output khct_pkg::job_t rd_data
);
	import khct_pkg::*;
	job_t buf_q [QDepth];
	logic [QPtrW-1:0] wp_q, rp_q;
	logic [QCntW-1:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != QCntW'(QDepth);
	assign rd_valid = cnt_q != '0;
	assign rd_data = buf_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + QCntW'(push) - QCntW'(pop);
		end
	end
endmodule

>>> rtl/khct_back.sv
`timescale 1ns / 1ps
// probe walk, each slot read (B_READ) and then checked (B_CHECK); clears the table after reset
module khct_back (
	input  logic clk,
	input  logic arst_n,
	input  logic [khct_pkg::SizeW-1:0] eff_size,
	input  logic job_valid,
	output logic job_ready,
	input  khct_pkg::job_t job,
	khct_out_if.source out_ch,
	output logic busy
);
	import khct_pkg::*;

	typedef enum logic [5:0] {
		B_CLEAR = 6'b000001,
		B_IDLE  = 6'b000010,
		B_READ  = 6'b000100,
		B_CHECK = 6'b001000,
		B_WRITE = 6'b010000,
		B_OUT   = 6'b100000
	} bstate_t;

	bstate_t state_q;
	logic [SlotW:0] clr_q;
	logic [SlotW-1:0] pos_q;
	logic [SizeW-1:0] n_q;
	job_t job_q;
	out_word_t res_q;
	logic ovalid_q;
	logic we;
	logic [SlotW-1:0] waddr;
	logic [MemW-1:0] wdata, rdata;
	logic r_used;
	logic [KeyW-1:0] r_key;
	logic [CountW-1:0] r_cnt, new_cnt;
	logic [SizeW-1:0] pos_ext;

	assign {r_used, r_key, r_cnt} = rdata;
	assign pos_ext = SizeW'(pos_q);

	khct_ram #(.Width(MemW), .Depth(TableDepth)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(pos_q), .rdata(rdata)
	);

	assign new_cnt = (!r_used) ? CountW'(1) : ((&r_cnt) ? r_cnt : r_cnt + 1'b1);

	always_comb begin
		we = 1'b0;
		waddr = pos_q;
		wdata = {1'b1, job_q.key, new_cnt};
		if (state_q == B_CLEAR) begin
			we = 1'b1;
			waddr = clr_q[SlotW-1:0];
			wdata = '0;
		end else if (state_q == B_WRITE) begin
			we = 1'b1;
		end
	end

	assign job_ready = (state_q == B_IDLE) && !ovalid_q;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data = res_q;
	assign busy = (state_q != B_IDLE) && (state_q != B_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ch.ready) ovalid_q <= 1'b0;
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (SlotW+1)'(TableDepth - 1)) state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (job_valid && job_ready) begin
						job_q <= job;
						pos_q <= job.start;
						n_q <= '0;
						state_q <= B_READ;
					end
				end
				B_READ: state_q <= B_CHECK;
				B_CHECK: begin
					if (!r_used || r_key == job_q.key) begin
						if (job_q.mode) begin
							res_q <= '{found: 1'b1, slot: pos_q, occurrences: new_cnt,
								table_full: 1'b0};
							state_q <= B_WRITE;
						end else begin
							res_q <= '{found: r_used, slot: r_used ? pos_q : '0,
								occurrences: r_used ? r_cnt : '0, table_full: 1'b0};
							state_q <= B_OUT;
						end
					end else if (n_q == eff_size - 1'b1) begin
						res_q <= '{found: 1'b0, slot: '0, occurrences: '0, table_full: 1'b1};
						state_q <= B_OUT;
					end else begin
						n_q <= n_q + 1'b1;
						pos_q <= (pos_ext + 1'b1 == eff_size) ? '0 : pos_q + 1'b1;
						state_q <= B_READ;
					end
				end
				B_WRITE: state_q <= B_OUT;
				B_OUT: begin
					ovalid_q <= 1'b1;
					state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/kmer_hash_count_table_core.sv
`timescale 1ns / 1ps
// Flow: the front hashes the 21 bases, then reduces the 64-bit hash modulo the table size
// one bit at a time; the job passes a two-entry queue into the back, which reads and then
// checks each probed slot, writes it for an insert, and then presents the result.
// Front and back each take one word at a time, and the slower side sets the pace.
// Reset: asynchronous; the back half clears all 4096 slots, one a cycle, before the
// first probe. table_size resets to 4096.
module kmer_hash_count_table_core (
	input  logic clk,
	input  logic arst_n,
	khct_cfg_if.sink cfg,
	khct_in_if.sink in_ch,
	khct_out_if.source out_ch
);
	import khct_pkg::*;

	logic [SizeW-1:0] size_q, eff_size;
	logic fj_valid, fj_ready, bj_valid, bj_ready, busy;
	job_t fj, bj;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_q <= SizeW'(TableDepth);
		else if (cfg.valid) size_q <= cfg.data;
	end
	assign eff_size = (size_q == '0) ? SizeW'(1) :
		(size_q > SizeW'(TableDepth)) ? SizeW'(TableDepth) : size_q;

	khct_front u_front (.clk(clk), .arst_n(arst_n), .eff_size(eff_size), .in_ch(in_ch),
		.job_valid(fj_valid), .job_ready(fj_ready), .job(fj));
	khct_queue u_queue (.clk(clk), .arst_n(arst_n), .wr_valid(fj_valid),
		.wr_ready(fj_ready), .wr_data(fj), .rd_valid(bj_valid), .rd_ready(bj_ready),
		.rd_data(bj));
	khct_back u_back (.clk(clk), .arst_n(arst_n), .eff_size(eff_size), .job_valid(bj_valid),
		.job_ready(bj_ready), .job(bj), .out_ch(out_ch), .busy(busy));

	a_out_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.data.found && out_ch.data.table_full))
		else $error("found and table_full together");
	a_start_range: assert property (@(posedge clk) disable iff (!arst_n)
		fj_valid |-> (SizeW'(fj.start) < eff_size))
		else $error("start slot out of range");
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.found) |-> (out_ch.data.occurrences != '0))
		else $error("found slot with zero count");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.valid && cfg.ready) |-> !busy)
		else $error("size written during a probe walk");
endmodule

>>> tb/tb_kmer_hash_count_table_core.sv
`timescale 1ns / 1ps
module tb_kmer_hash_count_table_core;
	import khct_pkg::*;

	localparam int CycleLimit = 3000000;
	localparam int DrainCycles = 300;
	localparam int PoolSize = 24;

	logic clk;
	logic arst_n;

	khct_cfg_if cfg_if();
	khct_in_if in_if();
	khct_out_if out_if();

	kmer_hash_count_table_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_if),
		.in_ch(in_if),
		.out_ch(out_if)
	);

	// table shadow
	logic table_used [TableDepth];
	logic [KeyW-1:0] table_key [TableDepth];
	logic [CountW-1:0] table_count [TableDepth];
	logic [SizeW-1:0] table_size;

	in_word_t pending_words[$];
	out_word_t lookup_results[$];
	logic [KeyW-1:0] key_pool [PoolSize];

	int errors = 0;
	int n_checked = 0;
	int n_hits = 0;
	int n_full = 0;
	int n_inserts = 0;
	longint cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic logic [HashW-1:0] sdbm_hash(input logic [KeyW-1:0] key);
		logic [HashW-1:0] h;
		logic [7:0] letter;
		h = '0;
		for (int i = KmerLen - 1; i >= 0; i--) begin
			case (key[2*i +: 2])
				2'd0: letter = "A";
				2'd1: letter = "C";
				2'd2: letter = "G";
				default: letter = "T";
			endcase
			h = HashW'(letter) + (h << ShiftA) + (h << ShiftB) - h;
		end
		return h;
	endfunction

	function automatic out_word_t lookup_kmer(input in_word_t w);
		out_word_t r;
		logic [KeyW-1:0] key;
		logic [HashW-1:0] eff;
		logic [HashW-1:0] pos;
		logic hit;
		logic empty;
		r = '0;
		key = w.kmer_bases[KeyW-1:0];
		eff = (table_size == 0) ? 1 : (table_size > TableDepth) ? TableDepth : table_size;
		pos = sdbm_hash(key) % eff;
		hit = 0;
		empty = 0;
		for (longint n = 0; n < eff; n++) begin
			if (!table_used[pos]) begin
				empty = 1;
				break;
			end
			if (table_key[pos] == key) begin
				hit = 1;
				break;
			end
			pos = (pos + 1) % eff;
		end
		if (!hit && !empty) begin
			r.table_full = 1;
			n_full++;
		end else if (w.mode) begin
			if (empty) begin
				table_used[pos] = 1;
				table_key[pos] = key;
				table_count[pos] = 0;
			end
			if (table_count[pos] != '1)
				table_count[pos] = table_count[pos] + 1;
			r.found = 1;
			r.slot = pos[SlotW-1:0];
			r.occurrences = table_count[pos];
			n_inserts++;
		end else if (hit) begin
			r.found = 1;
			r.slot = pos[SlotW-1:0];
			r.occurrences = table_count[pos];
			n_hits++;
		end
		return r;
	endfunction

	// sender: random bursts and gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_if.valid && in_if.ready)
				lookup_results.push_back(lookup_kmer(pending_words.pop_front()));
			if (!(in_if.valid && !in_if.ready)) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
				end
				if (gap_left > 0) begin
					gap_left--;
					in_if.valid <= 0;
				end else if (pending_words.size() > 0) begin
					burst_left--;
					in_if.valid <= 1;
					in_if.data <= pending_words[0];
				end else begin
					in_if.valid <= 0;
				end
			end
		end else begin
			in_if.valid <= 0;
			in_if.data <= '0;
		end
	end

	// receiver: stall pattern switches among four random modes
	always @(posedge clk) begin
		cycles++;
		if (cycles % 256 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_if.ready <= 1;
			1: out_if.ready <= ($urandom_range(0, 3) != 0);
			2: out_if.ready <= ($urandom_range(0, 3) == 0);
			default: out_if.ready <= ((cycles / 37) % 2 == 0);
		endcase
		if (arst_n && out_if.valid && out_if.ready) begin
			if (lookup_results.size() == 0) begin
				$display("%0t: unexpected word %p", $time, out_if.data);
				errors++;
			end else begin
				out_word_t e;
				e = lookup_results.pop_front();
				n_checked++;
				if (out_if.data.found !== e.found) begin
					$display("%0t: found exp %0d got %0d", $time, e.found, out_if.data.found);
					errors++;
				end
				if (out_if.data.slot !== e.slot) begin
					$display("%0t: slot exp %0d got %0d", $time, e.slot, out_if.data.slot);
					errors++;
				end
				if (out_if.data.occurrences !== e.occurrences) begin
					$display("%0t: occurrences exp %0d got %0d", $time, e.occurrences,
						out_if.data.occurrences);
					errors++;
				end
				if (out_if.data.table_full !== e.table_full) begin
					$display("%0t: table_full exp %0d got %0d", $time, e.table_full,
						out_if.data.table_full);
					errors++;
				end
			end
		end
		if (cycles > CycleLimit) begin
			$display("%0t: timeout", $time);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic push_word(input logic mode, input logic [KmerW-1:0] bases);
		in_word_t w;
		w.mode = mode;
		w.kmer_bases = bases;
		pending_words.push_back(w);
	endtask

	function automatic logic [KmerW-1:0] random_bases();
		return KmerW'({$urandom, $urandom});
	endfunction

	task automatic push_random(input int count);
		logic [KmerW-1:0] b;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) < 7) begin
				b = KmerW'(key_pool[$urandom_range(0, PoolSize - 1)]);
				if ($urandom_range(0, 1))
					b[KmerW-1:KeyW] = (KmerW-KeyW)'($urandom);
			end else begin
				b = random_bases();
			end
			push_word($urandom_range(0, 9) < 6, b);
		end
	endtask

	task automatic wait_idle();
		while (pending_words.size() > 0 || lookup_results.size() > 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_size(input logic [SizeW-1:0] v);
		cfg_if.valid <= 1;
		cfg_if.data <= v;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 0;
		table_size = v;
	endtask

	task automatic run_phase(input logic [SizeW-1:0] size, input int count);
		wait_idle();
		write_size(size);
		for (int i = 0; i < PoolSize; i++)
			if ($urandom_range(0, 2) == 0)
				key_pool[i] = KeyW'(random_bases());
		push_random(count);
	endtask

	initial begin
		arst_n = 0;
		cfg_if.valid = 0;
		cfg_if.data = '0;
		for (int i = 0; i < TableDepth; i++) begin
			table_used[i] = 0;
			table_count[i] = '0;
		end
		table_size = SizeW'(TableDepth);
		for (int i = 0; i < PoolSize; i++)
			key_pool[i] = KeyW'(random_bases());
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_size(SizeW'(TableDepth));
		// directed: absent search, insert/search pairs, extreme keys, upper bits ignored
		push_word(0, '0);
		push_word(1, '0);
		push_word(1, '0);
		push_word(0, '0);
		push_word(0, {KmerW{1'b1}});
		push_word(1, {KmerW{1'b1}});
		push_word(0, KmerW'({KeyW{1'b1}}));
		push_word(1, {{(KmerW-KeyW){1'b1}}, {KeyW{1'b0}}});
		push_word(0, {{(KmerW-KeyW){1'b1}}, {KeyW{1'b0}}});
		push_word(1, KmerW'(42'h15555555555));
		push_word(1, KmerW'(42'h2aaaaaaaaaa));
		push_word(0, KmerW'(42'h15555555555));
		push_word(0, 62'h2aaaaaaaaaaaaaaa);
		push_word(0, 62'h1555555555555555);
		push_random(180);

		run_phase(1, 20);
		run_phase(2, 30);
		run_phase(7, 60);
		run_phase(37, 150);
		run_phase(0, 20);
		run_phase(8191, 150);
		run_phase(SizeW'(TableDepth), 160);
		run_phase(4095, 30);

		wait_idle();
		if (lookup_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, lookup_results.size());
			errors++;
		end
		$display("checked %0d words over sizes 4096/1/2/7/37/0/8191/4096/4095", n_checked);
		$display("inserts %0d, search hits %0d, full-table results %0d", n_inserts, n_hits,
			n_full);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
